[src/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg: euler to quaternion shared types and constants
// Payload structs, Q30 format constants and helpers shared by all modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package e2q_pkg;

   localparam int QBITS = 30;
   localparam int ANGLE_W = 16;
   localparam int QUAT_W = 16;
   // sine/cosine magnitude in q30, including the value one
   localparam int MAG_W = QBITS + 1;
   // signed q30 value with magnitude up to one
   localparam int SQ_W = QBITS + 2;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] yaw_angle;
   } req_word_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
   } rsp_word_type;

   // table index and sign of one half angle
   typedef struct packed {
      logic neg;
      logic [15:0] idx;
   } half_angle_type;

   typedef struct packed {
      half_angle_type roll;
      half_angle_type pitch;
      half_angle_type yaw;
   } angle_set_type;

   // round a q60 magnitude back to q30, half up
   function automatic logic [MAG_W-1:0] rnd_q30(input logic [2*MAG_W-1:0] m);
      logic [2*MAG_W:0] t;
      t = {1'b0, m} + (2*MAG_W+1)'(64'd1 << (QBITS - 1));
      return MAG_W'(t >> QBITS);
   endfunction

endpackage

[src/e2q_front.sv]
// ----------------------------------------------------------------------------
// e2q_front: angle classification
// Folds each angle to a sign and a quarter-wave table index, one word a cycle unless the output is held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module e2q_front
   import e2q_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  req_word_type  in_word,
   output logic          out_valid,
   input  logic          out_ready,
   output angle_set_type out_set
);

   localparam int SH = 15 - SINE_TABLE_BITS;
   localparam logic [16:0] FULL = 17'(1) << SINE_TABLE_BITS;

   logic          valid_ff, valid_in;
   angle_set_type set_ff, set_in;

   function automatic half_angle_type classify(input logic [15:0] raw);
      half_angle_type h;
      logic [16:0] mag;
      logic [17:0] k;
      h.neg = raw[15];
      mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      k = ({1'b0, mag} + 18'((18'd1 << SH) >> 1)) >> SH;
      if (k > {1'b0, FULL}) k = {1'b0, FULL};
      h.idx = k[15:0];
      return h;
   endfunction

   // single output register, stalls only when held
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   always_comb begin
      set_in = set_ff;
      if (in_ready && in_valid) begin
         set_in.roll  = classify(in_word.roll_angle);
         set_in.pitch = classify(in_word.pitch_angle);
         set_in.yaw   = classify(in_word.yaw_angle);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      set_ff <= set_in;
   end

   assign out_valid = valid_ff;
   assign out_set   = set_ff;

endmodule

[src/e2q_queue.sv]
// ----------------------------------------------------------------------------
// e2q_queue: two-entry word queue
// Decouples the front from the back so that each may stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module e2q_queue
   import e2q_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  angle_set_type in_word,
   output logic          out_valid,
   input  logic          out_ready,
   output angle_set_type out_word
);

   angle_set_type mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign count_in = count_ff + 2'(push) - 2'(pop);
   assign out_word = mem_ff[rptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= in_word;
   end

endmodule

[src/e2q_back.sv]
// ----------------------------------------------------------------------------
// e2q_back: quaternion arithmetic pipeline
// Table lookup, two product stages, sum and rounding, with stall-all control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module e2q_back
   import e2q_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  angle_set_type in_set,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_word_type  out_word
);

   localparam int DEPTH = (1 << SINE_TABLE_BITS) + 1;
   localparam int IW = SINE_TABLE_BITS + 1;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // long division by shift and subtract, for the table build only
   function automatic logic [63:0] const_quot(input logic [63:0] num,
                                              input logic [63:0] den);
      logic [63:0] q, r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // quarter-wave sine entry, built at elaboration
   function automatic logic [MAG_W-1:0] sine_entry(input int k);
      logic [63:0] x, x2, term, t, d;
      logic signed [63:0] sum;
      x = (HALF_PI_Q30 * 64'(k) + (64'd1 << (SINE_TABLE_BITS - 1))) >> SINE_TABLE_BITS;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = $signed(x);
      for (int n = 1; n <= 8; n++) begin
         d = 64'((2 * n) * (2 * n + 1));
         t = (term * x2 + (64'd1 << 29)) >> 30;
         term = const_quot(t + (d >> 1), d);
         if (n[0]) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      return MAG_W'(sum);
   endfunction

   typedef logic [MAG_W-1:0] table_type [DEPTH];
   function automatic table_type build_table();
      table_type t;
      for (int k = 0; k < DEPTH; k++) t[k] = sine_entry(k);
      return t;
   endfunction
   localparam table_type SINE_TAB = build_table();

   // signed q30 product rounded, halves away from zero
   function automatic logic signed [SQ_W-1:0] mul_q30(input logic signed [SQ_W-1:0] a,
                                                      input logic signed [SQ_W-1:0] b);
      logic neg;
      logic [MAG_W-1:0] ua, ub, m;
      neg = a[SQ_W-1] ^ b[SQ_W-1];
      ua = MAG_W'(a[SQ_W-1] ? -a : a);
      ub = MAG_W'(b[SQ_W-1] ? -b : b);
      m = rnd_q30({{MAG_W{1'b0}}, ua} * {{MAG_W{1'b0}}, ub});
      return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   // q30 sum to output format, rounded and saturated
   function automatic logic [QUAT_W-1:0] to_out(input logic signed [SQ_W+1:0] v);
      localparam int SH = QBITS - OUT_FRAC_BITS;
      logic neg;
      logic [SQ_W+1:0] m;
      logic [SQ_W+1:0] lim;
      logic [SQ_W+1:0] r;
      neg = v[SQ_W+1];
      m = neg ? -v : v;
      lim = (SQ_W+2)'(1) << OUT_FRAC_BITS;
      if (SH > 0) m = (m + ((SQ_W+2)'(1) << (SH - 1))) >> SH;
      if (m > lim) m = lim;
      r = neg ? -m : m;
      return r[QUAT_W-1:0];
   endfunction

   logic advance;
   logic [3:0] v_ff;
   // stage 1: sines and cosines
   logic signed [SQ_W-1:0] sr_ff, cr_ff, sp_ff, cp_ff, sy_ff, cy_ff;
   // stage 2: pair products, keeps the third factors
   logic signed [SQ_W-1:0] ccr_ff, csr_ff, scr_ff, ssr_ff, sp2_ff, cp2_ff;
   // stage 3: eight triple products
   logic signed [SQ_W-1:0] tp_ff [8];
   // stage 4: result
   rsp_word_type word_ff;

   function automatic logic signed [SQ_W-1:0] lookup(input logic [15:0] idx, input logic neg,
                                                    input logic cosine);
      logic [IW-1:0] i;
      logic [MAG_W-1:0] m;
      i = cosine ? IW'((1 << SINE_TABLE_BITS) - int'(idx)) : IW'(idx);
      m = SINE_TAB[i];
      return (neg && !cosine) ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   // whole pipeline moves unless the result is held
   assign advance  = !v_ff[3] || out_ready;
   assign in_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 4'd0;
      end else if (advance) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sr_ff <= lookup(in_set.roll.idx, in_set.roll.neg, 1'b0);
         cr_ff <= lookup(in_set.roll.idx, in_set.roll.neg, 1'b1);
         sp_ff <= lookup(in_set.pitch.idx, in_set.pitch.neg, 1'b0);
         cp_ff <= lookup(in_set.pitch.idx, in_set.pitch.neg, 1'b1);
         sy_ff <= lookup(in_set.yaw.idx, in_set.yaw.neg, 1'b0);
         cy_ff <= lookup(in_set.yaw.idx, in_set.yaw.neg, 1'b1);
         ccr_ff <= mul_q30(cy_ff, cr_ff);
         csr_ff <= mul_q30(cy_ff, sr_ff);
         scr_ff <= mul_q30(sy_ff, cr_ff);
         ssr_ff <= mul_q30(sy_ff, sr_ff);
         sp2_ff <= sp_ff;
         cp2_ff <= cp_ff;
         tp_ff[0] <= mul_q30(ccr_ff, cp2_ff);
         tp_ff[1] <= mul_q30(ssr_ff, sp2_ff);
         tp_ff[2] <= mul_q30(csr_ff, cp2_ff);
         tp_ff[3] <= mul_q30(scr_ff, sp2_ff);
         tp_ff[4] <= mul_q30(ccr_ff, sp2_ff);
         tp_ff[5] <= mul_q30(ssr_ff, cp2_ff);
         tp_ff[6] <= mul_q30(scr_ff, cp2_ff);
         tp_ff[7] <= mul_q30(csr_ff, sp2_ff);
         word_ff.quat_w <= to_out(34'(tp_ff[0]) + 34'(tp_ff[1]));
         word_ff.quat_x <= to_out(34'(tp_ff[2]) - 34'(tp_ff[3]));
         word_ff.quat_y <= to_out(34'(tp_ff[4]) + 34'(tp_ff[5]));
         word_ff.quat_z <= to_out(34'(tp_ff[6]) - 34'(tp_ff[7]));
      end
   end

   assign out_valid = v_ff[3];
   assign out_word  = word_ff;

endmodule

[src/euler_to_quaternion.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion: zyx euler angles to unit quaternion
// Half-angle sine/cosine lookup, triple products, rounded q1.14 output.
//
//   channel | direction | word          | handshake
//   req_    | in        | req_word_type | req_valid / req_ready
//   rsp_    | out       | rsp_word_type | rsp_valid / rsp_ready
//
// One word per cycle while rsp_ready is high; path: front register, queue,
// four arithmetic stages. The product stages set the clock: one 31x31 multiply.
// Reset is synchronous and clears only valid and pointer state.
// A held result stalls the back; the two-entry queue lets the front run on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic          f_valid, f_ready, b_valid, b_ready;
   angle_set_type f_set, b_set;

   e2q_front #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_word(req_word),
      .out_valid(f_valid), .out_ready(f_ready), .out_set(f_set)
   );

   e2q_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_word(f_set),
      .out_valid(b_valid), .out_ready(b_ready), .out_word(b_set)
   );

   e2q_back #(.SINE_TABLE_BITS(SINE_TABLE_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_ready(b_ready), .in_set(b_set),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_word(rsp_word)
   );

endmodule

[src/e2q_checker.sv]
// ----------------------------------------------------------------------------
// e2q_checker: port behaviour checks
// Watches the top level ports for handshake stability and idle behaviour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module e2q_checker
   import e2q_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // held result keeps valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp_valid dropped");

   // held result keeps value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word)) else $error("rsp_word changed");

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp_valid after reset");

   // an idle output side never blocks input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && !$past(reset) |-> req_ready)
      else $error("req_ready low while empty output");

   // a waiting input word keeps valid
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid) else $error("req_valid dropped");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_word
);

[tb/sv/euler_to_quaternion_test.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion_test: testbench for the euler to quaternion converter
// Drives angle words with random idling, predicts each quaternion with an
// independent fixed-point model and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module euler_to_quaternion_test;
   import e2q_pkg::*;

   localparam int TABLE_BITS = 10;
   localparam int FRAC_BITS = 14;
   localparam longint HALF_PI = 64'd1686629713;
   localparam int WATCHDOG = 5000;

   // quarter-wave sine value in q30 for table step k
   function automatic longint quarter_sine(int unsigned k);
      longint unsigned x, x2, term, t, d;
      longint acc;
      x = (HALF_PI * k + (64'd1 << (TABLE_BITS - 1))) >> TABLE_BITS;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         d = longint'(2 * n) * longint'(2 * n + 1);
         t = (term * x2 + (64'd1 << 29)) >> 30;
         term = (t + d / 2) / d;
         if (n % 2 == 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
      return acc;
   endfunction

   // q30 product, halves away from zero
   function automatic longint qmul(longint a, longint b);
      longint unsigned ma, mb, m;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb + (64'd1 << 29)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [15:0] to_q14(longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (m > (64'd1 << FRAC_BITS)) m = 64'd1 << FRAC_BITS;
      return (v < 0) ? 16'(-longint'(m)) : 16'(m);
   endfunction

   function automatic void half_trig(logic signed [15:0] a, output longint s,
                                     output longint c);
      int unsigned mag, k;
      mag = a[15] ? (32'h10000 - {16'h0, a}) : {16'h0, a};
      k = (mag + (1 << (14 - TABLE_BITS))) >> (15 - TABLE_BITS);
      if (k > (1 << TABLE_BITS)) k = 1 << TABLE_BITS;
      s = a[15] ? -quarter_sine(k) : quarter_sine(k);
      c = quarter_sine((1 << TABLE_BITS) - k);
   endfunction

   function automatic rsp_word_type predict_quat(req_word_type r);
      longint sr, cr, sp, cp, sy, cy;
      rsp_word_type q;
      half_trig(r.roll_angle, sr, cr);
      half_trig(r.pitch_angle, sp, cp);
      half_trig(r.yaw_angle, sy, cy);
      q.quat_w = to_q14(qmul(qmul(cy, cr), cp) + qmul(qmul(sy, sr), sp));
      q.quat_x = to_q14(qmul(qmul(cy, sr), cp) - qmul(qmul(sy, cr), sp));
      q.quat_y = to_q14(qmul(qmul(cy, cr), sp) + qmul(qmul(sy, sr), cp));
      q.quat_z = to_q14(qmul(qmul(sy, cr), cp) - qmul(qmul(cy, sr), sp));
      return q;
   endfunction

   // in-order store of predicted quaternions
   class quat_scoreboard;
      rsp_word_type pending[$];
      int errors = 0;
      int checked = 0;

      function void note_angles(req_word_type r);
         pending.push_back(predict_quat(r));
      endfunction

      function void check_quat(rsp_word_type got);
         rsp_word_type want;
         if (pending.size() == 0) begin
            $error("unexpected result word %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.quat_w !== want.quat_w) begin
            $error("quat_w expected %0d actual %0d", want.quat_w, got.quat_w);
            errors++;
         end
         if (got.quat_x !== want.quat_x) begin
            $error("quat_x expected %0d actual %0d", want.quat_x, got.quat_x);
            errors++;
         end
         if (got.quat_y !== want.quat_y) begin
            $error("quat_y expected %0d actual %0d", want.quat_y, got.quat_y);
            errors++;
         end
         if (got.quat_z !== want.quat_z) begin
            $error("quat_z expected %0d actual %0d", want.quat_z, got.quat_z);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_word_type rsp_word;

   quat_scoreboard board = new();
   bit no_idle = 0;
   int quiet_cycles = 0;
   int sent = 0;

   euler_to_quaternion u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // result side: random stalls, checks on accept
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_quat(rsp_word);
      rsp_ready <= no_idle || ($urandom_range(99) >= 17);
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("euler_to_quaternion_test failed");
         $finish;
      end
   end

   task automatic send_angles(logic signed [15:0] r, logic signed [15:0] p,
                              logic signed [15:0] y);
      while (!no_idle && $urandom_range(99) < 17) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_word <= '{roll_angle: r, pitch_angle: p, yaw_angle: y};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_angles(req_word);
      sent++;
   endtask

   task automatic random_angle(output logic signed [15:0] a);
      case ($urandom_range(5))
         0: a = 16'sh8000;
         1: a = 16'sh7fff;
         2: a = 16'($urandom_range(64)) - 16'sd32;
         default: a = 16'($urandom);
      endcase
   endtask

   initial begin
      logic signed [15:0] ra, pa, ya;
      logic signed [15:0] corners [8] = '{16'sh8000, 16'sh7fff, 16'sh0000,
         16'sh4000, -16'sh4000, 16'sh0001, -16'sh0001, 16'sh0010};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed corners: each axis alone, then all extreme together
      for (int i = 0; i < 8; i++) send_angles(corners[i], 0, 0);
      for (int i = 0; i < 8; i++) send_angles(0, corners[i], 0);
      for (int i = 0; i < 8; i++) send_angles(0, 0, corners[i]);
      send_angles(16'sh8000, 16'sh8000, 16'sh8000);
      // drain pause before random part
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      for (int i = 0; i < 1300; i++) begin
         no_idle = (i >= 500 && i < 700);
         random_angle(ra);
         random_angle(pa);
         random_angle(ya);
         send_angles(ra, pa, ya);
      end
      no_idle = 0;
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d angle words incl. axis corners and -half-turn; %0d checked",
               sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("euler_to_quaternion_test passed");
      else
         $display("euler_to_quaternion_test failed");
      $finish;
   end

endmodule
